// ===== rtl/core/dda_pkg.sv =====
// Shared widths and constants for the DDA line rasteriser.
`default_nettype none
package dda_pkg;
	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int REM_BITS   = COORD_BITS + 1;
	localparam int QUO_BITS   = FRAC_BITS + 1;
	localparam int INC_BITS   = FRAC_BITS + 2;
	localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
	localparam int CNT_BITS   = $clog2(FRAC_BITS + 1);
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_STEP  = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/core/dda_div.sv =====
// Iterative restoring divider giving the fixed-point step increment magnitude.
`default_nettype none
module dda_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [dda_pkg::COORD_BITS-1:0] mag,
	input  wire logic [dda_pkg::COORD_BITS-1:0] den,
	output logic                               done,
	output logic [dda_pkg::QUO_BITS-1:0]       quo
);
	import dda_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [REM_BITS-1:0]   r_q;
	logic [COORD_BITS-1:0] den_q;
	logic [QUO_BITS-1:0]   q_q;
	logic [REM_BITS-1:0]   trial;
	logic [REM_BITS-1:0]   den_ext;
	logic                  ge;

	assign den_ext = {1'b0, den_q};
	assign trial   = (cnt_q == '0) ? r_q : {r_q[REM_BITS-2:0], 1'b0};
	assign ge      = (trial >= den_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_BITS'(1);
			if (cnt_q == CNT_BITS'(FRAC_BITS)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= {1'b0, mag};
			den_q <= den;
			q_q   <= '0;
		end else if (busy_q) begin
			r_q <= ge ? (trial - den_ext) : trial;
			q_q <= {q_q[QUO_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = q_q;

	a_busy_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && done_q))
		else $error("divider busy and done together");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q != '0 && den_q != '0) |-> (r_q < den_ext))
		else $error("divider remainder out of range");
endmodule
`default_nettype wire

// ===== rtl/core/dda_line_rasterizer_unit.sv =====
// Top level of the DDA line rasteriser: sequencer, accumulators and output register.
// A load transfer (op = 0) takes both endpoints and produces no result; the block then
// keeps in_ready low while one shared restoring divider, one quotient bit per cycle,
// works out first the x and then the y increment. A step transfer (op = 1) is taken
// every cycle while the output register is free or being emptied, and yields one
// pixel from the accumulators, the final one carrying last_pixel. A step with no line
// loaded produces nothing.
`default_nettype none
module dda_line_rasterizer_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 op,
	input  wire logic signed [dda_pkg::COORD_BITS-1:0] start_x,
	input  wire logic signed [dda_pkg::COORD_BITS-1:0] start_y,
	input  wire logic signed [dda_pkg::COORD_BITS-1:0] end_x,
	input  wire logic signed [dda_pkg::COORD_BITS-1:0] end_y,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [dda_pkg::COORD_BITS-1:0]      pixel_x,
	output logic signed [dda_pkg::COORD_BITS-1:0]      pixel_y,
	output logic                                      last_pixel
);
	import dda_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIVX = 2'd1;
	localparam logic [1:0] ST_DIVY = 2'd2;

	logic [1:0]            state_q;
	logic [COORD_BITS-1:0] mag_y_q;
	logic [COORD_BITS-1:0] steps_q;
	logic                  sign_x_q;
	logic                  sign_y_q;
	logic [INC_BITS-1:0]   inc_x_q;
	logic [INC_BITS-1:0]   inc_y_q;
	logic [ACC_BITS-1:0]   acc_x_q;
	logic [ACC_BITS-1:0]   acc_y_q;
	logic [COORD_BITS-1:0] steps_left_q;
	logic                  line_active_q;
	logic                  out_valid_q;
	logic [COORD_BITS-1:0] pixel_x_q;
	logic [COORD_BITS-1:0] pixel_y_q;
	logic                  last_pixel_q;

	logic                  in_fire;
	logic                  load_fire;
	logic                  step_fire;
	logic [DIFF_BITS-1:0]  dx;
	logic [DIFF_BITS-1:0]  dy;
	logic [DIFF_BITS-1:0]  ax_full;
	logic [DIFF_BITS-1:0]  ay_full;
	logic [COORD_BITS-1:0] ax;
	logic [COORD_BITS-1:0] ay;
	logic [COORD_BITS-1:0] steps;
	logic                  div_start;
	logic [COORD_BITS-1:0] div_mag;
	logic [COORD_BITS-1:0] div_den;
	logic                  div_done;
	logic [QUO_BITS-1:0]   div_quo;
	logic                  div_sign;
	logic [INC_BITS-1:0]   quo_ext;
	logic [INC_BITS-1:0]   inc_new;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;
	assign load_fire = in_fire && (op == OP_LOAD);
	assign step_fire = in_fire && (op == OP_STEP) && line_active_q;

	assign dx      = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
	assign dy      = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
	assign ax_full = dx[DIFF_BITS-1] ? (~dx + DIFF_BITS'(1)) : dx;
	assign ay_full = dy[DIFF_BITS-1] ? (~dy + DIFF_BITS'(1)) : dy;
	assign ax      = ax_full[COORD_BITS-1:0];
	assign ay      = ay_full[COORD_BITS-1:0];
	assign steps   = (ax > ay) ? ax : ay;

	assign div_start = load_fire || ((state_q == ST_DIVX) && div_done);
	assign div_mag   = load_fire ? ax : mag_y_q;
	assign div_den   = load_fire ? steps : steps_q;

	dda_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag    (div_mag),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign div_sign = (state_q == ST_DIVX) ? sign_x_q : sign_y_q;
	assign quo_ext  = {1'b0, div_quo};
	assign inc_new  = (steps_q == '0) ? '0 : (div_sign ? (~quo_ext + INC_BITS'(1)) : quo_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			line_active_q <= 1'b0;
			steps_left_q  <= '0;
			out_valid_q   <= 1'b0;
			acc_x_q       <= '0;
			acc_y_q       <= '0;
			inc_x_q       <= '0;
			inc_y_q       <= '0;
		end else begin
			if (step_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (load_fire) begin
						state_q       <= ST_DIVX;
						line_active_q <= 1'b0;
						steps_left_q  <= steps;
						acc_x_q       <= {start_x[COORD_BITS-1], start_x, 1'b1,
							{(FRAC_BITS-1){1'b0}}};
						acc_y_q       <= {start_y[COORD_BITS-1], start_y, 1'b1,
							{(FRAC_BITS-1){1'b0}}};
					end else if (step_fire) begin
						if (steps_left_q == '0) begin
							line_active_q <= 1'b0;
						end else begin
							acc_x_q      <= acc_x_q + {{(ACC_BITS-INC_BITS){inc_x_q[INC_BITS-1]}},
								inc_x_q};
							acc_y_q      <= acc_y_q + {{(ACC_BITS-INC_BITS){inc_y_q[INC_BITS-1]}},
								inc_y_q};
							steps_left_q <= steps_left_q - COORD_BITS'(1);
						end
					end
				end
				ST_DIVX: begin
					if (div_done) begin
						inc_x_q <= inc_new;
						state_q <= ST_DIVY;
					end
				end
				ST_DIVY: begin
					if (div_done) begin
						inc_y_q       <= inc_new;
						line_active_q <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_fire) begin
			mag_y_q  <= ay;
			steps_q  <= steps;
			sign_x_q <= dx[DIFF_BITS-1];
			sign_y_q <= dy[DIFF_BITS-1];
		end
		if (step_fire) begin
			pixel_x_q    <= acc_x_q[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
			pixel_y_q    <= acc_y_q[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
			last_pixel_q <= (steps_left_q == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_x    = pixel_x_q;
	assign pixel_y    = pixel_y_q;
	assign last_pixel = last_pixel_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIVX || state_q == ST_DIVY))
		else $error("divider result outside a division state");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(step_fire && steps_left_q == '0) |=> (!line_active_q && out_valid && last_pixel))
		else $error("final pixel did not end the line");

	a_inc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		line_active_q |-> ($signed(inc_x_q) <= $signed(INC_BITS'(1) << FRAC_BITS) &&
			$signed(inc_x_q) >= -$signed(INC_BITS'(1) << FRAC_BITS) &&
			$signed(inc_y_q) <= $signed(INC_BITS'(1) << FRAC_BITS) &&
			$signed(inc_y_q) >= -$signed(INC_BITS'(1) << FRAC_BITS)))
		else $error("step increment exceeds one pixel");
endmodule
`default_nettype wire

// ===== bench/tb_dda_line_rasterizer_unit.sv =====
// Self-checking testbench for the DDA line rasteriser with a built-in pixel predictor.
`default_nettype none
module tb_dda_line_rasterizer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import dda_pkg::*;

	typedef struct {
		logic                         op;
		logic signed [COORD_BITS-1:0] sx;
		logic signed [COORD_BITS-1:0] sy;
		logic signed [COORD_BITS-1:0] ex;
		logic signed [COORD_BITS-1:0] ey;
		bit                           drain;
	} line_cmd_t;

	typedef struct {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  last;
	} pixel_t;

	localparam int QUIET_FROM = 1000;
	localparam int QUIET_TO   = 1600;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic                         op = OP_LOAD;
	logic signed [COORD_BITS-1:0] start_x = '0;
	logic signed [COORD_BITS-1:0] start_y = '0;
	logic signed [COORD_BITS-1:0] end_x = '0;
	logic signed [COORD_BITS-1:0] end_y = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic                         last_pixel;

	line_cmd_t line_cmds[$];
	pixel_t    pending_pixels[$];
	bit        in_taken = 1'b0;
	int        cycle_count = 0;
	int        pixels_seen = 0;
	int        fail_count = 0;
	int        stall_left = 0;
	bit        stall_done = 1'b0;

	longint    pos_x = 0;
	longint    pos_y = 0;
	longint    stride_x = 0;
	longint    stride_y = 0;
	longint    steps_to_go = 0;
	bit        tracing = 1'b0;

	dda_line_rasterizer_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last_pixel (last_pixel)
	);

	always #1 clk = ~clk;

	function automatic longint stride_of(longint d, longint n);
		longint mag;
		if (n <= 0 || d == 0) begin
			return 0;
		end
		mag = ((d < 0 ? -d : d) * (longint'(1) << FRAC_BITS)) / n;
		return d < 0 ? -mag : mag;
	endfunction

	function automatic int clamp_coord(int v);
		if (v < -(1 << (COORD_BITS - 1))) begin
			return -(1 << (COORD_BITS - 1));
		end
		if (v > (1 << (COORD_BITS - 1)) - 1) begin
			return (1 << (COORD_BITS - 1)) - 1;
		end
		return v;
	endfunction

	task automatic trace_transfer(logic cmd_op, longint sx, longint sy, longint ex, longint ey);
		longint dx;
		longint dy;
		longint ax;
		longint ay;
		pixel_t px;
		if (cmd_op == OP_LOAD) begin
			dx = ex - sx;
			dy = ey - sy;
			ax = dx < 0 ? -dx : dx;
			ay = dy < 0 ? -dy : dy;
			steps_to_go = ax > ay ? ax : ay;
			stride_x = stride_of(dx, steps_to_go);
			stride_y = stride_of(dy, steps_to_go);
			pos_x = sx * (longint'(1) << FRAC_BITS) + (longint'(1) << (FRAC_BITS - 1));
			pos_y = sy * (longint'(1) << FRAC_BITS) + (longint'(1) << (FRAC_BITS - 1));
			tracing = 1'b1;
		end else if (tracing) begin
			px.x = COORD_BITS'(pos_x >>> FRAC_BITS);
			px.y = COORD_BITS'(pos_y >>> FRAC_BITS);
			if (steps_to_go == 0) begin
				px.last = 1'b1;
				tracing = 1'b0;
			end else begin
				px.last = 1'b0;
				pos_x += stride_x;
				pos_y += stride_y;
				steps_to_go--;
			end
			pending_pixels.push_back(px);
		end
	endtask

	task automatic queue_load(int sx, int sy, int ex, int ey, bit drain);
		line_cmd_t c;
		c.op = OP_LOAD;
		c.sx = COORD_BITS'(sx);
		c.sy = COORD_BITS'(sy);
		c.ex = COORD_BITS'(ex);
		c.ey = COORD_BITS'(ey);
		c.drain = drain;
		line_cmds.push_back(c);
	endtask

	task automatic queue_steps(int n, bit drain);
		line_cmd_t c;
		c.op = OP_STEP;
		c.sx = COORD_BITS'($urandom);
		c.sy = COORD_BITS'($urandom);
		c.ex = COORD_BITS'($urandom);
		c.ey = COORD_BITS'($urandom);
		c.drain = drain;
		repeat (n) begin
			line_cmds.push_back(c);
			c.drain = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Checking comes before prediction, as a pixel never leaves in the cycle its step is taken.
	always @(posedge clk) begin
		pixel_t want;
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			pixels_seen <= pixels_seen + 1;
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $time,
					pixel_x, pixel_y, last_pixel);
				fail_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (pixel_x !== want.x) begin
					$display("%0t: pixel_x expected %0d actual %0d", $time,
						$signed(want.x), pixel_x);
					fail_count++;
				end
				if (pixel_y !== want.y) begin
					$display("%0t: pixel_y expected %0d actual %0d", $time,
						$signed(want.y), pixel_y);
					fail_count++;
				end
				if (last_pixel !== want.last) begin
					$display("%0t: last_pixel expected %0b actual %0b", $time,
						want.last, last_pixel);
					fail_count++;
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			trace_transfer(op, start_x, start_y, end_x, end_y);
		end
	end

	always @(negedge clk) begin
		line_cmd_t c;
		bit        idle;
		idle = (cycle_count < QUIET_FROM || cycle_count >= QUIET_TO) &&
			$urandom_range(0, 99) < 15;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (line_cmds.size() > 0 && !idle &&
				!(line_cmds[0].drain && pending_pixels.size() > 0)) begin
				c = line_cmds.pop_front();
				op <= c.op;
				start_x <= c.sx;
				start_y <= c.sy;
				end_x <= c.ex;
				end_y <= c.ey;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!stall_done && pixels_seen >= 150) begin
			stall_done <= 1'b1;
			stall_left <= 80;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !((cycle_count < QUIET_FROM || cycle_count >= QUIET_TO) &&
				$urandom_range(0, 99) < 15);
		end
	end

	initial begin
		#400000;
		$display("dda_line_rasterizer_unit verification failed");
		$finish;
	end

	initial begin
		int counted;
		int kind;
		int span;
		int sx;
		int sy;
		int ex;
		int ey;
		int n;
		int ax;
		int ay;

		queue_steps(1, 1'b0);
		queue_load(0, 0, 0, 0, 1'b0);
		queue_steps(2, 1'b0);
		queue_load(-2048, -2048, 2047, 2047, 1'b0);
		queue_steps(3, 1'b0);
		queue_load(2047, -2048, -2048, 2047, 1'b0);
		queue_steps(2, 1'b0);
		queue_load(0, 0, 1, -2, 1'b0);
		queue_steps(3, 1'b0);
		queue_load(0, 0, -1, 2, 1'b0);
		queue_steps(3, 1'b0);
		queue_load(-2048, 2047, -2048, 2047, 1'b0);
		queue_steps(2, 1'b0);

		counted = 0;
		n = $urandom_range(256, 511);
		sx = $urandom_range(0, 4095 - n) - 2048;
		sy = $urandom_range(0, 4095) - 2048;
		ey = clamp_coord(sy + $urandom_range(0, 2 * n) - n);
		if ($urandom_range(0, 1) == 1) begin
			queue_load(sx, sy, sx + n, ey, 1'b1);
		end else begin
			queue_load(sx + n, ey, sx, sy, 1'b1);
		end
		queue_steps(n + 1, 1'b0);
		counted += n + 2;

		while (counted < 600) begin
			kind = $urandom_range(0, 99);
			sx = $urandom_range(0, 4095) - 2048;
			sy = $urandom_range(0, 4095) - 2048;
			if (kind < 80) begin
				span = ($urandom_range(0, 9) == 0) ? 200 : 24;
				ex = clamp_coord(sx + $urandom_range(0, 2 * span) - span);
				ey = clamp_coord(sy + $urandom_range(0, 2 * span) - span);
				queue_load(sx, sy, ex, ey, $urandom_range(0, 49) == 0);
				ax = ex > sx ? ex - sx : sx - ex;
				ay = ey > sy ? ey - sy : sy - ey;
				n = (ax > ay ? ax : ay) + 1;
				if ($urandom_range(0, 9) == 0) begin
					n = $urandom_range(0, n);
					queue_steps(n, 1'b0);
				end else begin
					queue_steps(n, 1'b0);
					queue_steps($urandom_range(0, 2), 1'b0);
				end
				counted += n + 1;
			end else if (kind < 90) begin
				ex = $urandom_range(0, 4095) - 2048;
				ey = $urandom_range(0, 4095) - 2048;
				queue_load(sx, sy, ex, ey, 1'b0);
				n = $urandom_range(0, 6);
				queue_steps(n, 1'b0);
				counted += n + 1;
			end else begin
				queue_steps(1, 1'b0);
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		@(negedge clk);
		while (line_cmds.size() > 0 || in_valid || pending_pixels.size() > 0) begin
			@(negedge clk);
		end
		repeat (60) @(posedge clk);
		if (fail_count == 0) begin
			$display("dda_line_rasterizer_unit verification clean");
		end else begin
			$display("dda_line_rasterizer_unit verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
